[rtl/modexp_pkg.sv]
// shared types and constants for the modular exponentiation core
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package modexp_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENC_EXPONENT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEC_EXPONENT = 2'd2;

   // register reset values
   localparam int RESET_MODULUS      = 143;
   localparam int RESET_ENC_EXPONENT = 7;
   localparam int RESET_DEC_EXPONENT = 223;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MUL_ACC,
      ST_MUL_SQR,
      ST_FINISH
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic red_step;
      logic base_from_red;
      logic mul_step;
      logic acc_write;
      logic base_write;
      logic mul_init_acc;
      logic mul_init_sqr;
      logic out_load;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic cnt_last;
      logic exp_bit;
      logic exp_zero;
   } status_type;

endpackage

`default_nettype wire

[rtl/modexp_datapath.sv]
// datapath: base reduction, shared shift-and-add modular multiplier, exponent shifter
// depends on modexp_pkg for the command and status structs
`default_nettype none

module modexp_datapath #(
   parameter int VALUE_WIDTH = 16
) (
   input  wire                        clock,
   input  wire modexp_pkg::cmd_type   cmd,
   input  wire                        req_type,
   input  wire  [VALUE_WIDTH-1:0]     req_message_value,
   input  wire  [VALUE_WIDTH-1:0]     modulus,
   input  wire  [VALUE_WIDTH-1:0]     enc_exponent,
   input  wire  [VALUE_WIDTH-1:0]     dec_exponent,
   output modexp_pkg::status_type     status,
   output logic [VALUE_WIDTH-1:0]     result_value
);
   import modexp_pkg::*;

   localparam int CNT_W = $clog2(VALUE_WIDTH);

   // (a + b) mod n for a, b below n
   function automatic logic [VALUE_WIDTH-1:0] add_mod(
      input logic [VALUE_WIDTH-1:0] a,
      input logic [VALUE_WIDTH-1:0] b,
      input logic [VALUE_WIDTH-1:0] n
   );
      logic [VALUE_WIDTH:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, n}) begin
         sum = sum - {1'b0, n};
      end
      return sum[VALUE_WIDTH-1:0];
   endfunction

   // one restoring step: (2r + bit) mod n for r below n
   function automatic logic [VALUE_WIDTH-1:0] reduce_step(
      input logic [VALUE_WIDTH-1:0] r,
      input logic                   bit_in,
      input logic [VALUE_WIDTH-1:0] n
   );
      logic [VALUE_WIDTH:0] wide;
      wide = {r, bit_in};
      if (wide >= {1'b0, n}) begin
         wide = wide - {1'b0, n};
      end
      return wide[VALUE_WIDTH-1:0];
   endfunction

   logic [VALUE_WIDTH-1:0] msg_ff, msg_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] base_ff, base_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] exp_ff, exp_in;
   logic [VALUE_WIDTH-1:0] ma_ff, ma_in;
   logic [VALUE_WIDTH-1:0] mb_ff, mb_in;
   logic [VALUE_WIDTH-1:0] prod_ff, prod_in;
   logic [VALUE_WIDTH-1:0] result_ff, result_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   logic [VALUE_WIDTH-1:0] red_next;
   logic [VALUE_WIDTH-1:0] prod_next;
   logic [VALUE_WIDTH-1:0] ma_next;

   assign red_next  = reduce_step(rem_ff, msg_ff[VALUE_WIDTH-1], modulus);
   assign prod_next = mb_ff[0] ? add_mod(prod_ff, ma_ff, modulus) : prod_ff;
   assign ma_next   = add_mod(ma_ff, ma_ff, modulus);

   always_comb begin
      msg_in    = msg_ff;
      rem_in    = rem_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      exp_in    = exp_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      prod_in   = prod_ff;
      result_in = result_ff;
      cnt_in    = cnt_ff;

      if (cmd.load) begin
         msg_in = req_message_value;
         rem_in = '0;
         cnt_in = '0;
         // one mod n: zero for a modulus of one
         acc_in = (modulus == VALUE_WIDTH'(1)) ? '0 : VALUE_WIDTH'(1);
         exp_in = req_type ? dec_exponent : enc_exponent;
      end
      if (cmd.red_step) begin
         msg_in = {msg_ff[VALUE_WIDTH-2:0], 1'b0};
         rem_in = red_next;
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.base_from_red) begin
         base_in = red_next;
      end
      if (cmd.mul_step) begin
         prod_in = prod_next;
         ma_in   = ma_next;
         mb_in   = {1'b0, mb_ff[VALUE_WIDTH-1:1]};
         cnt_in  = cnt_ff + CNT_W'(1);
      end
      if (cmd.acc_write) begin
         acc_in = prod_next;
      end
      if (cmd.base_write) begin
         base_in = prod_next;
         exp_in  = {1'b0, exp_ff[VALUE_WIDTH-1:1]};
      end
      if (cmd.mul_init_acc) begin
         ma_in   = acc_ff;
         mb_in   = base_ff;
         prod_in = '0;
         cnt_in  = '0;
      end
      if (cmd.mul_init_sqr) begin
         ma_in   = base_ff;
         mb_in   = base_ff;
         prod_in = '0;
         cnt_in  = '0;
      end
      if (cmd.out_load) begin
         // a zero modulus gives no reduction, result forced to zero
         result_in = (modulus == '0) ? '0 : acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff    <= msg_in;
      rem_ff    <= rem_in;
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      exp_ff    <= exp_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      prod_ff   <= prod_in;
      result_ff <= result_in;
      cnt_ff    <= cnt_in;
   end

   assign status.cnt_last = (cnt_ff == CNT_W'(VALUE_WIDTH - 1));
   assign status.exp_bit  = exp_ff[0];
   assign status.exp_zero = (exp_ff == '0);
   assign result_value    = result_ff;

endmodule

`default_nettype wire

[rtl/modexp_ctrl.sv]
// controller: sequences reduction, multiplies and result handoff
// depends on modexp_pkg for state, command and status types
`default_nettype none

module modexp_ctrl (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   input  wire modexp_pkg::status_type status,
   output modexp_pkg::cmd_type         cmd
);
   import modexp_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.red_step = 1'b1;
            if (status.cnt_last) begin
               cmd.base_from_red = 1'b1;
               state_in          = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.exp_zero) begin
               state_in = ST_FINISH;
            end else if (status.exp_bit) begin
               cmd.mul_init_acc = 1'b1;
               state_in         = ST_MUL_ACC;
            end else begin
               cmd.mul_init_sqr = 1'b1;
               state_in         = ST_MUL_SQR;
            end
         end
         ST_MUL_ACC: begin
            cmd.mul_step = 1'b1;
            if (status.cnt_last) begin
               cmd.acc_write    = 1'b1;
               cmd.mul_init_sqr = 1'b1;
               state_in         = ST_MUL_SQR;
            end
         end
         ST_MUL_SQR: begin
            cmd.mul_step = 1'b1;
            if (status.cnt_last) begin
               cmd.base_write = 1'b1;
               state_in       = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   // an accepted word always starts with base reduction
   a_accept_reduce: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_REDUCE))
      else $error("accepted word did not start reduction");

   // a taken result with no new load leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !cmd.out_load) |=> !rsp_valid_ff)
      else $error("result valid not cleared after handoff");

   // the end of a squaring returns to the exponent bit check
   a_sqr_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_SQR && status.cnt_last) |=> (state_ff == ST_CHECK))
      else $error("squaring did not return to bit check");

endmodule

`default_nettype wire

[rtl/modular_exponentiation_core.sv]
// top level of the modular exponentiation core: config registers, controller, datapath
// depends on modexp_pkg, modexp_ctrl and modexp_datapath
//
//   channel  | direction | handshake            | payload
//   req      | in        | req_valid/req_stall  | req_type, req_message_value
//   rsp      | out       | rsp_valid/rsp_stall  | rsp_result_value
//   csr      | in        | csr_write_en         | csr_index, csr_wdata
//
// one word at a time; the run time of a word grows with W = VALUE_WIDTH, with k, the bit length
// of the selected exponent, and with p, its count of ones
// it is set by the shared shift-and-add multiplier, one multiplier bit per cycle
// synchronous active-high reset returns the controller to idle, registers to 143 / 7 / 223
// a finished result waits in the output register under rsp_stall; req is taken again at once
`default_nettype none

module modular_exponentiation_core #(
   parameter int VALUE_WIDTH = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // request channel
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire                                   req_type,
   input  wire  [VALUE_WIDTH-1:0]                req_message_value,
   // response channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [VALUE_WIDTH-1:0]                rsp_result_value,
   // configuration writes
   input  wire                                   csr_write_en,
   input  wire  [modexp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire  [VALUE_WIDTH-1:0]                csr_wdata
);
   import modexp_pkg::*;

   // configuration registers; the user writes them only while the core is idle, the core does not enforce it
   logic [VALUE_WIDTH-1:0] modulus_ff, modulus_in;
   logic [VALUE_WIDTH-1:0] enc_exp_ff, enc_exp_in;
   logic [VALUE_WIDTH-1:0] dec_exp_ff, dec_exp_in;

   cmd_type    cmd;
   status_type status;

   // register decode, unknown index is dropped
   always_comb begin
      modulus_in = modulus_ff;
      enc_exp_in = enc_exp_ff;
      dec_exp_in = dec_exp_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MODULUS:      modulus_in = csr_wdata;
            CSR_ENC_EXPONENT: enc_exp_in = csr_wdata;
            CSR_DEC_EXPONENT: dec_exp_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= VALUE_WIDTH'(RESET_MODULUS);
         enc_exp_ff <= VALUE_WIDTH'(RESET_ENC_EXPONENT);
         dec_exp_ff <= VALUE_WIDTH'(RESET_DEC_EXPONENT);
      end else begin
         modulus_ff <= modulus_in;
         enc_exp_ff <= enc_exp_in;
         dec_exp_ff <= dec_exp_in;
      end
   end

   // sequencer: handshakes and step commands
   modexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic: reduction, multiplier, exponent bits, output register
   modexp_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .req_type          (req_type),
      .req_message_value (req_message_value),
      .modulus           (modulus_ff),
      .enc_exponent      (enc_exp_ff),
      .dec_exponent      (dec_exp_ff),
      .status            (status),
      .result_value      (rsp_result_value)
   );

endmodule

`default_nettype wire

[bench/tb.sv]
// self-checking bench for modular_exponentiation_core: directed rows, then random phases
// depends on modexp_pkg and the core rtl; predicts results not typed into the rows with a local square-and-multiply
`default_nettype none

module tb;
   import modexp_pkg::*;

   localparam int W            = 16;
   localparam int PHASES       = 10;
   localparam int PHASE_WORDS  = 52;
   localparam int LONG_HOLD    = 3000;      // receiver hold-off, well past two full exponentiations
   localparam int DRAIN_CYCLES = 600;       // idle run after the final drain
   localparam int MAX_REPORTS  = 10;
   localparam int LIMIT        = 6_000_000; // watchdog limit in time units

   // no register lives at this index; writes to it must be dropped
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 2'd3;

   typedef enum logic {REQ_ENCRYPT, REQ_DECRYPT} request_type;
   typedef enum logic {ROW_WORD, ROW_WRITE} row_kind_type;

   // one directed step: either a request word or a register write
   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_WIDTH-1:0] index;
      request_type                rtype;
      logic [W-1:0]               value;   // message for a word, data for a write
      logic                       known;   // answer typed in below
      logic [W-1:0]               answer;
   } stim_row_type;

   // a word in flight, with the result it must come back with
   typedef struct packed {
      request_type  rtype;
      logic [W-1:0] message;
      logic [W-1:0] result;
   } pending_type;

   logic                       clock             = 1'b0;
   logic                       reset             = 1'b1;
   logic                       req_valid         = 1'b0;
   logic                       req_type          = 1'b0;
   logic [W-1:0]               req_message_value = '0;
   logic                       rsp_stall         = 1'b0;
   logic                       csr_write_en      = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index         = '0;
   logic [W-1:0]               csr_wdata         = '0;
   wire                        req_stall;
   wire                        rsp_valid;
   wire  [W-1:0]               rsp_result_value;

   // local copy of the configuration, updated as each write goes out
   logic [W-1:0] shadow_modulus      = W'(RESET_MODULUS);
   logic [W-1:0] shadow_enc_exponent = W'(RESET_ENC_EXPONENT);
   logic [W-1:0] shadow_dec_exponent = W'(RESET_DEC_EXPONENT);

   pending_type awaited[$];
   int          mismatch_count = 0;
   bit          sender_idling  = 1'b1;
   bit          rsp_idling     = 1'b1;
   bit          long_hold_req  = 1'b0;
   int          stall_left     = 0;

   // directed rows; reset keys are the textbook pair n = 11*13, e = 7, d = 223
   stim_row_type directed_rows[$] = '{
      '{ROW_WORD,  CSR_MODULUS,      REQ_ENCRYPT, 16'd0,      1'b1, 16'd0},
      '{ROW_WORD,  CSR_MODULUS,      REQ_ENCRYPT, 16'd1,      1'b1, 16'd1},
      '{ROW_WORD,  CSR_MODULUS,      REQ_ENCRYPT, 16'd2,      1'b1, 16'd128},
      '{ROW_WORD,  CSR_MODULUS,      REQ_DECRYPT, 16'd128,    1'b1, 16'd2},
      '{ROW_WORD,  CSR_MODULUS,      REQ_ENCRYPT, 16'd142,    1'b1, 16'd142},
      '{ROW_WORD,  CSR_MODULUS,      REQ_ENCRYPT, 16'd143,    1'b1, 16'd0},
      '{ROW_WORD,  CSR_MODULUS,      REQ_ENCRYPT, 16'd144,    1'b1, 16'd1},
      '{ROW_WORD,  CSR_MODULUS,      REQ_ENCRYPT, 16'hffff,   1'b0, 16'd0},
      '{ROW_WORD,  CSR_MODULUS,      REQ_DECRYPT, 16'hffff,   1'b0, 16'd0},
      // widest modulus, all-ones and zero exponents
      '{ROW_WRITE, CSR_MODULUS,      REQ_ENCRYPT, 16'hffff,   1'b0, 16'd0},
      '{ROW_WRITE, CSR_ENC_EXPONENT, REQ_ENCRYPT, 16'hffff,   1'b0, 16'd0},
      '{ROW_WRITE, CSR_DEC_EXPONENT, REQ_ENCRYPT, 16'd0,      1'b0, 16'd0},
      '{ROW_WORD,  CSR_MODULUS,      REQ_ENCRYPT, 16'hfffe,   1'b1, 16'hfffe},
      '{ROW_WORD,  CSR_MODULUS,      REQ_ENCRYPT, 16'h5a5a,   1'b0, 16'd0},
      '{ROW_WORD,  CSR_MODULUS,      REQ_DECRYPT, 16'd12345,  1'b1, 16'd1},
      '{ROW_WORD,  CSR_MODULUS,      REQ_DECRYPT, 16'd0,      1'b1, 16'd1},
      // modulus of one: everything reduces to zero
      '{ROW_WRITE, CSR_MODULUS,      REQ_ENCRYPT, 16'd1,      1'b0, 16'd0},
      '{ROW_WORD,  CSR_MODULUS,      REQ_ENCRYPT, 16'd5,      1'b1, 16'd0},
      '{ROW_WORD,  CSR_MODULUS,      REQ_DECRYPT, 16'd0,      1'b1, 16'd0},
      // modulus of zero: no reduction, result forced to zero
      '{ROW_WRITE, CSR_MODULUS,      REQ_ENCRYPT, 16'd0,      1'b0, 16'd0},
      '{ROW_WORD,  CSR_MODULUS,      REQ_ENCRYPT, 16'd7,      1'b1, 16'd0},
      '{ROW_WORD,  CSR_MODULUS,      REQ_DECRYPT, 16'hffff,   1'b1, 16'd0},
      // smallest legal modulus
      '{ROW_WRITE, CSR_MODULUS,      REQ_ENCRYPT, 16'd2,      1'b0, 16'd0},
      '{ROW_WORD,  CSR_MODULUS,      REQ_ENCRYPT, 16'd3,      1'b1, 16'd1},
      '{ROW_WORD,  CSR_MODULUS,      REQ_ENCRYPT, 16'd4,      1'b1, 16'd0},
      // largest 16-bit prime, unit exponent, top-bit exponent, then a dropped write
      '{ROW_WRITE, CSR_MODULUS,      REQ_ENCRYPT, 16'd65521,  1'b0, 16'd0},
      '{ROW_WRITE, CSR_ENC_EXPONENT, REQ_ENCRYPT, 16'd1,      1'b0, 16'd0},
      '{ROW_WRITE, CSR_DEC_EXPONENT, REQ_ENCRYPT, 16'h8000,   1'b0, 16'd0},
      '{ROW_WRITE, CSR_UNMAPPED,     REQ_ENCRYPT, 16'd0,      1'b0, 16'd0},
      '{ROW_WORD,  CSR_MODULUS,      REQ_ENCRYPT, 16'hffff,   1'b1, 16'd14},
      '{ROW_WORD,  CSR_MODULUS,      REQ_ENCRYPT, 16'h8000,   1'b1, 16'h8000},
      '{ROW_WORD,  CSR_MODULUS,      REQ_DECRYPT, 16'd3,      1'b0, 16'd0},
      '{ROW_WORD,  CSR_MODULUS,      REQ_DECRYPT, 16'ha5a5,   1'b0, 16'd0}
   };

   modular_exponentiation_core #(
      .VALUE_WIDTH(W)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_message_value(req_message_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   // right-to-left square-and-multiply; a zero modulus gives zero
   function automatic logic [W-1:0] expmod(logic [W-1:0] base, logic [W-1:0] power,
                                           logic [W-1:0] modulus);
      logic [2*W-1:0] acc;
      logic [2*W-1:0] sq;
      logic [2*W-1:0] n;
      if (modulus == '0) return '0;
      n   = modulus;
      acc = 1 % n;
      sq  = base % n;
      for (int i = 0; i < W; i++) begin
         if (power[i]) acc = (acc * sq) % n;
         sq = (sq * sq) % n;
      end
      return acc[W-1:0];
   endfunction

   // idle lengths: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 24);
      return $urandom_range(60, 300);
   endfunction

   // moduli lean on the edges; zero and one show up now and then
   function automatic logic [W-1:0] pick_modulus();
      case ($urandom_range(0, 9))
         0: return '1;
         1: return W'(2);
         2: return W'(3);
         3: return W'($urandom_range(0, 1));
         4, 5: return W'($urandom_range(2, 255));
         default: return W'($urandom_range(2, 65535));
      endcase
   endfunction

   // short exponents keep the run quick; full-width and edge values still appear
   function automatic logic [W-1:0] pick_exponent();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return W'(1);
         3, 4, 5: return W'($urandom_range(2, 255));
         default: return W'($urandom_range(0, 65535));
      endcase
   endfunction

   // bases: full range for bit coverage, plus values around the modulus
   function automatic logic [W-1:0] pick_message();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return shadow_modulus - W'(1);
         3: return shadow_modulus + W'($urandom_range(0, 2));
         4, 5: return W'($urandom_range(0, 65535)) % ((shadow_modulus == '0) ? W'(1)
                                                                           : shadow_modulus);
         default: return W'($urandom_range(0, 65535));
      endcase
   endfunction

   // one register write, enable high for a single edge
   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] index, logic [W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (index)
         CSR_MODULUS:      shadow_modulus      = data;
         CSR_ENC_EXPONENT: shadow_enc_exponent = data;
         CSR_DEC_EXPONENT: shadow_dec_exponent = data;
         default: ;        // unmapped, dropped by the core
      endcase
      @(posedge clock);
   endtask

   // offer one word and hold it until taken; valid stays up when no gap follows
   task automatic offer_word(request_type rtype, logic [W-1:0] msg, logic known,
                             logic [W-1:0] answer);
      pending_type item;
      int          gap;
      req_valid         <= 1'b1;
      req_type          <= rtype;
      req_message_value <= msg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      item.rtype   = rtype;
      item.message = msg;
      item.result  = known ? answer
                   : expmod(msg, (rtype == REQ_DECRYPT) ? shadow_dec_exponent
                                                        : shadow_enc_exponent,
                            shadow_modulus);
      awaited.push_back(item);
      gap = sender_idling ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid and wait until every outstanding word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
   endtask

   // receiver: random stall runs, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
         end else if (rsp_idling && $urandom_range(0, 2) == 0) begin
            stall_left = pick_gap();
         end
      end
   end

   // result check: each accepted word against the oldest expectation
   always @(posedge clock) begin : result_check
      pending_type head;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result word %0d", rsp_result_value);
         end else begin
            head = awaited.pop_front();
            if (rsp_result_value !== head.result) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("result mismatch: %s of %0d, expected %0d, got %0d",
                           head.rtype.name(), head.message, head.result, rsp_result_value);
            end
         end
      end
   end

   // stimulus
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed rows; writes only once the core has gone quiet
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            drain_results();
            write_reg(directed_rows[i].index, directed_rows[i].value);
         end else begin
            offer_word(directed_rows[i].rtype, directed_rows[i].value,
                       directed_rows[i].known, directed_rows[i].answer);
         end
      end

      // random phases, each with a fresh key set
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         write_reg(CSR_MODULUS, pick_modulus());
         write_reg(CSR_ENC_EXPONENT, pick_exponent());
         write_reg(CSR_DEC_EXPONENT, pick_exponent());
         sender_idling = (p % 3 != 1);
         rsp_idling    = (p % 4 != 2);
         // back-to-back sender against a long receiver hold fills the core
         if (p == 1) long_hold_req = 1'b1;
         for (int i = 0; i < PHASE_WORDS; i++) begin
            // sender pause mid-phase until the core is empty
            if (p == 4 && i == PHASE_WORDS / 2) drain_results();
            offer_word(request_type'($urandom_range(0, 1)), pick_message(), 1'b0, '0);
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(LIMIT);
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
